// ===== rtl/cfpw_pkg.sv =====
// Shared types and constants for the chained fixup pointer walker.
`default_nettype none

package cfpw_pkg;

   localparam int unsigned OutDepth     = 4;
   localparam int unsigned OutPtrWidth  = $clog2(OutDepth);
   localparam int unsigned OutCntWidth  = $clog2(OutDepth + 1);
   localparam int unsigned ReqDataWidth = 128;
   localparam int unsigned RspDataWidth = 136;

   typedef enum logic [1:0] {
      ST_FETCH = 2'd0,
      ST_BIND  = 2'd1,
      ST_DONE  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_FORMAT      = 3'd0,
      CSR_SEG_START   = 3'd1,
      CSR_SEG_END     = 3'd2,
      CSR_STO_SEG_BASE = 3'd3,
      CSR_STO_SEG_SIZE = 3'd4,
      CSR_STO_SIZE    = 3'd5,
      CSR_SEG_INDEX   = 3'd6
   } csr_index_type;

   localparam logic [2:0] FMT_ARM64E_LAST = 3'd2;
   localparam logic [2:0] FMT_ARM64E_U24  = 3'd2;
   localparam logic [2:0] FMT_PTR64_LAST  = 3'd4;

   typedef struct packed {
      logic [2:0]  ptr_layout;
      logic [63:0] seg_start;
      logic [63:0] seg_end;
      logic [63:0] sto_seg_start;
      logic [63:0] sto_seg_size;
      logic [63:0] sto_size;
      logic [7:0]  seg_index;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [63:0]        address;
      logic [23:0]        ordinal;
      logic               is_auth;
      logic [1:0]         auth_key;
      logic [15:0]        diversity;
      logic               addr_div;
      logic signed [18:0] addend;
      logic [7:0]         bind_segment;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/cfpw_decode.sv =====
// Decode of one walker item: bounds checks, pointer decode and next walker state.
`default_nettype none

module cfpw_decode (
   input  var cfpw_pkg::cfg_type    cfg,
   input  wire                      kind,
   input  wire [63:0]               start_offset,
   input  wire [63:0]               raw_word,
   input  wire                      busy,
   input  wire [63:0]               cur_offset,
   output logic [1:0]               res_count,
   output cfpw_pkg::result_type     res0,
   output cfpw_pkg::result_type     res1,
   output logic                     busy_next,
   output logic [63:0]              offset_next
);
   import cfpw_pkg::*;

   function automatic logic bounds_ok(input logic [63:0] off, input cfg_type c);
      logic [63:0] rel_off;
      logic [63:0] rel_off8;
      logic [63:0] room;
      rel_off   = off - c.seg_start;
      rel_off8  = rel_off + 64'd8;
      room      = c.sto_size - c.sto_seg_start;
      bounds_ok = (off >= c.seg_start) && (off <= c.seg_end) &&
                  ((c.seg_end - off) >= 64'd8) && (rel_off8 <= c.sto_seg_size) &&
                  (c.sto_seg_start <= c.sto_size) && (rel_off8 <= room);
   endfunction

   logic        arm;
   logic        fmt_known;
   logic        is_auth;
   logic        is_bind;
   logic [11:0] next;
   logic [63:0] step;
   logic [63:0] advanced;
   logic        start_ok;
   logic        adv_ok;
   result_type  tail;
   result_type  bind_res;

   assign arm       = cfg.ptr_layout <= FMT_ARM64E_LAST;
   assign fmt_known = cfg.ptr_layout <= FMT_PTR64_LAST;
   assign is_auth   = arm && raw_word[63];
   assign is_bind   = arm ? raw_word[62] : raw_word[63];
   assign next      = arm ? {1'b0, raw_word[61:51]} : raw_word[62:51];

   // stride is 8 for arm64e, 4 for ptr64, nothing for an unknown format
   always_comb begin
      if (arm) begin
         step = {49'd0, next, 3'd0};
      end else if (fmt_known) begin
         step = {50'd0, next, 2'd0};
      end else begin
         step = 64'd0;
      end
   end

   assign advanced = cur_offset + step;
   assign start_ok = bounds_ok(start_offset, cfg);
   assign adv_ok   = bounds_ok(advanced, cfg);

   always_comb begin
      bind_res              = '0;
      bind_res.status       = ST_BIND;
      bind_res.address      = cur_offset;
      bind_res.bind_segment = cfg.seg_index;
      bind_res.is_auth      = is_auth;
      if (arm) begin
         bind_res.ordinal = (cfg.ptr_layout == FMT_ARM64E_U24) ?
                            raw_word[23:0] : {8'd0, raw_word[15:0]};
         if (is_auth) begin
            bind_res.diversity = raw_word[47:32];
            bind_res.addr_div  = raw_word[48];
            bind_res.auth_key  = raw_word[50:49];
         end else begin
            bind_res.addend = raw_word[50:32];
         end
      end else begin
         bind_res.ordinal = raw_word[23:0];
         bind_res.addend  = {11'd0, raw_word[31:24]};
      end
   end

   always_comb begin
      tail        = '0;
      tail.last   = 1'b1;
      tail.status = ST_BAD;
      busy_next   = 1'b0;
      offset_next = cur_offset;
      res_count   = 2'd1;
      if (!kind) begin
         if (fmt_known && start_ok) begin
            tail.status  = ST_FETCH;
            tail.address = cfg.sto_seg_start + (start_offset - cfg.seg_start);
            busy_next    = 1'b1;
            offset_next  = start_offset;
         end
      end else if (!busy) begin
         res_count = 2'd0;
      end else begin
         res_count = is_bind ? 2'd2 : 2'd1;
         if (next == 12'd0) begin
            tail.status = ST_DONE;
         end else if (advanced > cur_offset && adv_ok) begin
            tail.status  = ST_FETCH;
            tail.address = cfg.sto_seg_start + (advanced - cfg.seg_start);
            busy_next    = 1'b1;
            offset_next  = advanced;
         end
      end
      res0 = (kind && is_bind) ? bind_res : tail;
      res1 = tail;
   end

endmodule

`default_nettype wire

// ===== rtl/chained_fixup_pointer_walker_top.sv =====
// Top level of the chained fixup pointer walker: ports, input stage and result queue.
//
// Walks one chain of 64-bit fixup pointers. A request transfer with tuser 0
// starts a chain at the image offset in tdata[63:0]; with tuser 1 it hands
// back the raw word that was fetched, in tdata[127:64]. Each request gives
// zero, one or two response transfers: a start gives a fetch request or
// malformed; a word gives an optional bind record, then a fetch request,
// chain done or malformed. tlast marks the final response of a request.
// A word that arrives with no chain running gives no response.
// A request is registered in the input stage, decoded from that register, and its
// responses are written into the four-entry result queue, whose head drives rsp.
// One request is taken per cycle while the queue has room for its responses;
// responses leave at one per cycle while rsp_tready is high, so requests with
// a bind record, which give two responses each, go no faster than the queue
// drains. The queue's free space sets when the input stage stalls.
// Registers are to be written through csr only while the block is idle; the block
// itself does not enforce this. csr_ready is always high. Reset clears the
// registers, the running chain and the queue. A stalled receiver holds the head
// response; requests keep flowing until the queue is full.
`default_nettype none

module chained_fixup_pointer_walker_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // start_offset [63:0], raw_word [127:64]
   input  wire [127:0] req_tdata,
   // kind [0]
   input  wire         req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // address [63:0], ordinal [87:64], is_auth [88], auth_key [90:89],
   // diversity [106:91], addr_div [107], addend [126:108],
   // bind_segment [134:127], zero [135]
   output logic [cfpw_pkg::RspDataWidth-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [2:0]   csr_index,
   input  wire [63:0]  csr_data
);
   import cfpw_pkg::*;

   cfg_type                 cfg_ff;
   logic                    in_valid_ff;
   logic                    in_kind_ff;
   logic [ReqDataWidth-1:0] in_data_ff;
   logic                    busy_ff;
   logic                    busy_in;
   logic [63:0]             offset_ff;
   logic [63:0]             offset_in;

   result_type              queue_ff [OutDepth];
   logic [OutPtrWidth-1:0]  wr_ptr_ff;
   logic [OutPtrWidth-1:0]  rd_ptr_ff;
   logic [OutCntWidth-1:0]  count_ff;
   logic [OutCntWidth-1:0]  count_in;
   logic [OutCntWidth-1:0]  space;

   logic [1:0]              res_count;
   result_type              res0;
   result_type              res1;
   result_type              head;
   logic                    fire;
   logic                    pop;
   logic [1:0]              push_n;

   cfpw_decode u_decode (
      .cfg          (cfg_ff),
      .kind         (in_kind_ff),
      .start_offset (in_data_ff[63:0]),
      .raw_word     (in_data_ff[127:64]),
      .busy         (busy_ff),
      .cur_offset   (offset_ff),
      .res_count    (res_count),
      .res0         (res0),
      .res1         (res1),
      .busy_next    (busy_in),
      .offset_next  (offset_in)
   );

   assign csr_ready  = 1'b1;
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = OutCntWidth'(OutDepth) - count_ff + {{(OutCntWidth-1){1'b0}}, pop};
   assign fire       = in_valid_ff && (space >= {{(OutCntWidth-2){1'b0}}, res_count});
   assign push_n     = fire ? res_count : 2'd0;
   assign req_tready = !in_valid_ff || fire;
   assign count_in   = count_ff + {{(OutCntWidth-2){1'b0}}, push_n} -
                       {{(OutCntWidth-1){1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FORMAT:       cfg_ff.ptr_layout    <= csr_data[2:0];
            CSR_SEG_START:    cfg_ff.seg_start     <= csr_data;
            CSR_SEG_END:      cfg_ff.seg_end       <= csr_data;
            CSR_STO_SEG_BASE: cfg_ff.sto_seg_start <= csr_data;
            CSR_STO_SEG_SIZE: cfg_ff.sto_seg_size  <= csr_data;
            CSR_STO_SIZE:     cfg_ff.sto_size      <= csr_data;
            CSR_SEG_INDEX:    cfg_ff.seg_index     <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // input stage, walker state and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         busy_ff     <= 1'b0;
         offset_ff   <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            busy_ff   <= busy_in;
            offset_ff <= offset_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_n[OutPtrWidth-1:0];
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OutPtrWidth'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + OutPtrWidth'(1)] <= res1;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tuser  = head.status;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {1'b0, head.bind_segment, head.addend, head.addr_div,
                        head.diversity, head.auth_key, head.is_auth, head.ordinal,
                        head.address};

endmodule

`default_nettype wire
